// File: sv/rti_pkg.sv
// shared widths and constants for the ray/triangle intersection pipeline
`default_nettype none
package rti_pkg;
	localparam int COORD_BITS = 21;
	localparam int FRAC_BITS  = 10;
	localparam int FIELD_W    = 63;
	localparam int DW    = COORD_BITS + 1;
	localparam int P2    = 2 * DW;
	localparam int XW    = 2 * DW + 1;
	localparam int XL    = DW + 1;
	localparam int XH    = XW - XL;
	localparam int LW    = DW + XL + 1;
	localparam int HW    = DW + XH;
	localparam int PW    = DW + XW;
	localparam int DOTW  = PW + 2;
	localparam int SW    = DOTW + 1;
	localparam int NW    = SW + 33;
	localparam int EW    = SW + 30;
	localparam int QW    = 32;
	localparam int DEW   = 20;
	localparam int TEW   = 16;
	localparam int DIST_FRAC = 16;
	localparam int LSH   = (3 * FRAC_BITS < 30) ? (30 - 3 * FRAC_BITS) : 0;
	localparam int RSH   = (3 * FRAC_BITS > 30) ? (3 * FRAC_BITS - 30) : 0;
	localparam logic [DEW-1:0] DET_EPS_RST = DEW'(107);
	localparam logic [TEW-1:0] T_EPS_RST   = '0;
	localparam logic REG_DET_EPS = 1'b0;
	localparam logic REG_T_EPS   = 1'b1;
endpackage
`default_nettype wire

// File: sv/ray_triangle_intersect.sv
// top level: pipelined Moller-Trumbore ray/triangle test with APB registers
`default_nettype none
// One ray/triangle transaction may start every cycle (busy is always low) and
// its result appears on done/hit/hit_distance for one cycle; the receiver
// cannot stall. The result passes through eight arithmetic stages (edges,
// cross products, split dot products, sign fix, tests), a 32-stage restoring
// divider that yields one quotient bit per stage and one output register for
// the distance threshold.
// Registers: det_epsilon at address 0, t_epsilon at address 4; write only
// while no transaction is in flight.
module ray_triangle_intersect (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rti_pkg::FIELD_W-1:0]   ray_origin,
	input  wire logic [rti_pkg::FIELD_W-1:0]   ray_direction,
	input  wire logic [rti_pkg::FIELD_W-1:0]   vertex_zero,
	input  wire logic [rti_pkg::FIELD_W-1:0]   vertex_one,
	input  wire logic [rti_pkg::FIELD_W-1:0]   vertex_two,
	output logic                               done,
	output logic                               hit,
	output logic [rti_pkg::QW-1:0]             hit_distance,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	localparam int CB  = rti_pkg::COORD_BITS;
	localparam int DW  = rti_pkg::DW;
	localparam int P2  = rti_pkg::P2;
	localparam int XW  = rti_pkg::XW;
	localparam int XL  = rti_pkg::XL;
	localparam int LW  = rti_pkg::LW;
	localparam int HW  = rti_pkg::HW;
	localparam int PW  = rti_pkg::PW;
	localparam int DOTW = rti_pkg::DOTW;
	localparam int SW  = rti_pkg::SW;
	localparam int NW  = rti_pkg::NW;
	localparam int EW  = rti_pkg::EW;
	localparam int QW  = rti_pkg::QW;

	logic [rti_pkg::DEW-1:0] det_eps_q;
	logic [rti_pkg::TEW-1:0] t_eps_q;

	// configuration port
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = (paddr[2] == rti_pkg::REG_T_EPS) ? 32'(t_eps_q) : 32'(det_eps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_eps_q <= rti_pkg::DET_EPS_RST;
			t_eps_q   <= rti_pkg::T_EPS_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == rti_pkg::REG_DET_EPS) begin
				det_eps_q <= pwdata[rti_pkg::DEW-1:0];
			end else begin
				t_eps_q <= pwdata[rti_pkg::TEW-1:0];
			end
		end
	end

	// stage 1: unpack and edges
	logic signed [CB-1:0] o_c[3], d_c[3], p0_c[3], p1_c[3], p2_c[3];
	logic                 v_s1;
	logic signed [DW-1:0] e1_s1[3], e2_s1[3], s_s1[3], d_s1[3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o_c[i]  = ray_origin[i*CB +: CB];
			d_c[i]  = ray_direction[i*CB +: CB];
			p0_c[i] = vertex_zero[i*CB +: CB];
			p1_c[i] = vertex_one[i*CB +: CB];
			p2_c[i] = vertex_two[i*CB +: CB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= DW'(p1_c[i]) - DW'(p0_c[i]);
			e2_s1[i] <= DW'(p2_c[i]) - DW'(p0_c[i]);
			s_s1[i]  <= DW'(o_c[i]) - DW'(p0_c[i]);
			d_s1[i]  <= DW'(d_c[i]);
		end
	end

	// stage 2: cross product terms
	logic                 v_s2;
	logic signed [P2-1:0] ha_s2[3], hb_s2[3], qa_s2[3], qb_s2[3];
	logic signed [DW-1:0] e1_s2[3], e2_s2[3], s_s2[3], d_s2[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ha_s2[i] <= P2'(d_s1[(i+1)%3]) * P2'(e2_s1[(i+2)%3]);
			hb_s2[i] <= P2'(d_s1[(i+2)%3]) * P2'(e2_s1[(i+1)%3]);
			qa_s2[i] <= P2'(s_s1[(i+1)%3]) * P2'(e1_s1[(i+2)%3]);
			qb_s2[i] <= P2'(s_s1[(i+2)%3]) * P2'(e1_s1[(i+1)%3]);
		end
		e1_s2 <= e1_s1;
		e2_s2 <= e2_s1;
		s_s2  <= s_s1;
		d_s2  <= d_s1;
	end

	// stage 3: cross products
	logic                 v_s3;
	logic signed [XW-1:0] h_s3[3], q_s3[3];
	logic signed [DW-1:0] e1_s3[3], e2_s3[3], s_s3[3], d_s3[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			h_s3[i] <= XW'(ha_s2[i]) - XW'(hb_s2[i]);
			q_s3[i] <= XW'(qa_s2[i]) - XW'(qb_s2[i]);
		end
		e1_s3 <= e1_s2;
		e2_s3 <= e2_s2;
		s_s3  <= s_s2;
		d_s3  <= d_s2;
	end

	// stage 4: dot product partial products, cross term split in two halves
	// dot 0: det = e1.h, 1: un = s.h, 2: vn = d.q, 3: tn = e2.q
	logic signed [DW-1:0] da_c[4][3];
	logic signed [XW-1:0] db_c[4][3];
	logic                 v_s4;
	logic signed [LW-1:0] pl_s4[4][3];
	logic signed [HW-1:0] ph_s4[4][3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			da_c[0][j] = e1_s3[j];
			db_c[0][j] = h_s3[j];
			da_c[1][j] = s_s3[j];
			db_c[1][j] = h_s3[j];
			da_c[2][j] = d_s3[j];
			db_c[2][j] = q_s3[j];
			da_c[3][j] = e2_s3[j];
			db_c[3][j] = q_s3[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++) begin
				pl_s4[k][j] <= LW'(da_c[k][j]) * LW'($signed({1'b0, db_c[k][j][XL-1:0]}));
				ph_s4[k][j] <= HW'(da_c[k][j]) * HW'($signed(db_c[k][j][XW-1:XL]));
			end
		end
	end

	// stage 5: recombine halves
	logic                 v_s5;
	logic signed [PW-1:0] pp_s5[4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++) begin
				pp_s5[k][j] <= (PW'(ph_s4[k][j]) <<< XL) + PW'(pl_s4[k][j]);
			end
		end
	end

	// stage 6: dot sums
	logic                   v_s6;
	logic signed [DOTW-1:0] dt_s6[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			dt_s6[k] <= DOTW'(pp_s5[k][0]) + DOTW'(pp_s5[k][1]) + DOTW'(pp_s5[k][2]);
		end
	end

	// stage 7: make det positive
	logic                 v_s7, z_s7;
	logic signed [SW-1:0] dn_s7[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		z_s7 <= (dt_s6[0] == '0);
		for (int k = 0; k < 4; k++) begin
			dn_s7[k] <= dt_s6[0][DOTW-1] ? -SW'(dt_s6[k]) : SW'(dt_s6[k]);
		end
	end

	// stage 8: acceptance tests and divider setup
	logic          [EW-1:0] lhs_c, rhs_c;
	logic signed [SW:0]     uv_c;
	logic                   ok_c;
	logic                   v_s8, ok_s8, sat_s8;
	logic          [NW-1:0] num_s8, den_s8;

	always_comb begin
		lhs_c = EW'(dn_s7[0]) << rti_pkg::LSH;
		rhs_c = EW'(det_eps_q) << rti_pkg::RSH;
		uv_c  = (SW+1)'(dn_s7[1]) + (SW+1)'(dn_s7[2]);
		ok_c  = !z_s7 && (lhs_c >= rhs_c)
		        && (dn_s7[1] >= 0) && (dn_s7[1] <= dn_s7[0])
		        && (dn_s7[2] >= 0) && (uv_c <= (SW+1)'(dn_s7[0]))
		        && (dn_s7[3] > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		ok_s8  <= ok_c;
		num_s8 <= NW'(dn_s7[3]) << rti_pkg::DIST_FRAC;
		den_s8 <= NW'(dn_s7[0]);
		sat_s8 <= ((NW'(dn_s7[3]) << rti_pkg::DIST_FRAC) >= (NW'(dn_s7[0]) << QW));
	end

	// stages 9 to 40: restoring divider, one quotient bit per stage
	logic          v_s9[QW], ok_s9[QW], sat_s9[QW];
	logic [NW-1:0] num_s9[QW], den_s9[QW];
	logic [QW-1:0] quo_s9[QW];
	logic [NW-1:0] pn_c[QW], pd_c[QW], tr_c[QW];
	logic [QW-1:0] pq_c[QW];

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			pn_c[k] = (k == 0) ? num_s8 : num_s9[(k == 0) ? 0 : k-1];
			pd_c[k] = (k == 0) ? den_s8 : den_s9[(k == 0) ? 0 : k-1];
			pq_c[k] = (k == 0) ? '0 : quo_s9[(k == 0) ? 0 : k-1];
			tr_c[k] = pd_c[k] << (QW - 1 - k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				v_s9[k] <= 1'b0;
			end
		end else begin
			v_s9[0] <= v_s8;
			for (int k = 1; k < QW; k++) begin
				v_s9[k] <= v_s9[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s9[0]  <= ok_s8;
		sat_s9[0] <= sat_s8;
		for (int k = 1; k < QW; k++) begin
			ok_s9[k]  <= ok_s9[k-1];
			sat_s9[k] <= sat_s9[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			den_s9[k] <= pd_c[k];
			if (pn_c[k] >= tr_c[k]) begin
				num_s9[k] <= pn_c[k] - tr_c[k];
				quo_s9[k] <= pq_c[k] | (QW'(1) << (QW - 1 - k));
			end else begin
				num_s9[k] <= pn_c[k];
				quo_s9[k] <= pq_c[k];
			end
		end
	end

	// output stage: distance threshold
	logic [QW-1:0] fq_c;
	logic          rem_c, hit_c;
	logic          done_q, hit_q;
	logic [QW-1:0] dist_q;

	always_comb begin
		fq_c  = sat_s9[QW-1] ? '1 : quo_s9[QW-1];
		rem_c = sat_s9[QW-1] || (num_s9[QW-1] != '0);
		hit_c = ok_s9[QW-1]
		        && ((fq_c > QW'(t_eps_q)) || ((fq_c == QW'(t_eps_q)) && rem_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s9[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		hit_q  <= hit_c;
		dist_q <= hit_c ? fq_c : '0;
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;
endmodule
`default_nettype wire

// File: tb/sv/ray_triangle_intersect_tb.sv
// testbench for ray_triangle_intersect: random and directed ray/triangle transactions vs predictor
`timescale 1ns / 1ps
module ray_triangle_intersect_tb;
	localparam int LATENCY = 41;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int FW = rti_pkg::FIELD_W;
	localparam int CBITS = rti_pkg::COORD_BITS;
	localparam int QW = rti_pkg::QW;

	typedef longint vec3_t[3];
	typedef struct {
		logic [FW-1:0] orig;
		logic [FW-1:0] dir;
		logic [FW-1:0] v0;
		logic [FW-1:0] v1;
		logic [FW-1:0] v2;
	} ray_tri_t;
	typedef struct {
		logic           hit;
		logic [QW-1:0]  distance;
	} hit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [FW-1:0] ray_origin = '0;
	logic [FW-1:0] ray_direction = '0;
	logic [FW-1:0] vertex_zero = '0;
	logic [FW-1:0] vertex_one = '0;
	logic [FW-1:0] vertex_two = '0;
	logic done;
	logic hit;
	logic [QW-1:0] hit_distance;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ray_tri_t pending_rays[$];
	hit_result_t expected_hits[$];
	logic [rti_pkg::DEW-1:0] det_eps_cfg = rti_pkg::DET_EPS_RST;
	logic [rti_pkg::TEW-1:0] t_eps_cfg = rti_pkg::T_EPS_RST;
	int idle_pct = 0;
	int mismatch_count = 0;
	int hits_seen = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	ray_triangle_intersect i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ray_origin(ray_origin), .ray_direction(ray_direction),
		.vertex_zero(vertex_zero), .vertex_one(vertex_one), .vertex_two(vertex_two),
		.done(done), .hit(hit), .hit_distance(hit_distance),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	function automatic longint coord_of(logic [FW-1:0] f, int i);
		logic signed [CBITS-1:0] c;
		c = f[i*CBITS +: CBITS];
		return longint'(c);
	endfunction

	function automatic logic [FW-1:0] pack3(longint x, longint y, longint z);
		logic [CBITS-1:0] cx, cy, cz;
		cx = x[CBITS-1:0];
		cy = y[CBITS-1:0];
		cz = z[CBITS-1:0];
		return {cz, cy, cx};
	endfunction

	function automatic logic signed [127:0] dot3(vec3_t a, vec3_t b);
		logic signed [127:0] acc;
		acc = 0;
		for (int i = 0; i < 3; i++)
			acc += 128'(signed'(a[i])) * 128'(signed'(b[i]));
		return acc;
	endfunction

	function automatic hit_result_t predict_hit(ray_tri_t it);
		vec3_t o, d, p0, p1, p2, e1, e2, s, h, q;
		logic signed [127:0] det, un, vn, tn, num;
		logic [QW-1:0] quo;
		bit rem;
		hit_result_t r;
		r.hit = 1'b0;
		r.distance = '0;
		for (int i = 0; i < 3; i++) begin
			o[i] = coord_of(it.orig, i);
			d[i] = coord_of(it.dir, i);
			p0[i] = coord_of(it.v0, i);
			p1[i] = coord_of(it.v1, i);
			p2[i] = coord_of(it.v2, i);
			e1[i] = p1[i] - p0[i];
			e2[i] = p2[i] - p0[i];
			s[i] = o[i] - p0[i];
		end
		h[0] = d[1] * e2[2] - d[2] * e2[1];
		h[1] = d[2] * e2[0] - d[0] * e2[2];
		h[2] = d[0] * e2[1] - d[1] * e2[0];
		q[0] = s[1] * e1[2] - s[2] * e1[1];
		q[1] = s[2] * e1[0] - s[0] * e1[2];
		q[2] = s[0] * e1[1] - s[1] * e1[0];
		det = dot3(e1, h);
		un = dot3(s, h);
		vn = dot3(d, q);
		tn = dot3(e2, q);
		if (det == 0) return r;
		if (det < 0) begin
			det = -det;
			un = -un;
			vn = -vn;
			tn = -tn;
		end
		if ((det <<< rti_pkg::LSH) < (128'(det_eps_cfg) <<< rti_pkg::RSH)) return r;
		if (un < 0 || un > det) return r;
		if (vn < 0 || un + vn > det) return r;
		if (tn <= 0) return r;
		num = tn <<< rti_pkg::DIST_FRAC;
		if (num >= (det <<< 32)) begin
			quo = '1;
			rem = 1'b1;
		end else begin
			quo = QW'(num / det);
			rem = (num % det) != 0;
		end
		if (quo < t_eps_cfg || (quo == t_eps_cfg && !rem)) return r;
		r.hit = 1'b1;
		r.distance = quo;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start)
				expected_hits.push_back(predict_hit('{ray_origin, ray_direction,
					vertex_zero, vertex_one, vertex_two}));
			if (pending_rays.size() > 0 && $urandom_range(99) >= idle_pct) begin
				ray_tri_t it;
				it = pending_rays.pop_front();
				start <= 1'b1;
				ray_origin <= it.orig;
				ray_direction <= it.dir;
				vertex_zero <= it.v0;
				vertex_one <= it.v1;
				vertex_two <= it.v2;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(string what, logic [QW-1:0] got, logic [QW-1:0] want);
		mismatch_count++;
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected transaction, hit", QW'(hit), '0);
			end else begin
				hit_result_t e;
				e = expected_hits.pop_front();
				if (hit !== e.hit) report_mismatch("hit", QW'(hit), QW'(e.hit));
				if (hit_distance !== e.distance)
					report_mismatch("hit_distance", hit_distance, e.distance);
				if (e.hit) hits_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done
		    || (pending_rays.size() == 0 && expected_hits.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d transactions outstanding", expected_hits.size());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic reg_code, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_code, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_code == rti_pkg::REG_DET_EPS) det_eps_cfg = value[rti_pkg::DEW-1:0];
		else t_eps_cfg = value[rti_pkg::TEW-1:0];
	endtask

	function automatic longint rand_coord(int mag);
		return longint'($urandom_range(2 * mag)) - mag;
	endfunction

	function automatic ray_tri_t aimed_ray();
		vec3_t v0, e1, e2, o, d;
		int a, b, k, mode;
		ray_tri_t it;
		a = $urandom_range(0, 280);
		b = $urandom_range(0, 290 - (a > 256 ? 256 : a));
		mode = $urandom_range(0, 9);
		k = $urandom_range(1, 7);
		for (int i = 0; i < 3; i++) begin
			v0[i] = rand_coord(1 << 17);
			e1[i] = rand_coord(1 << $urandom_range(4, 16));
			e2[i] = rand_coord(1 << $urandom_range(4, 16));
			o[i] = rand_coord(1 << 17);
			d[i] = v0[i] + ((longint'(a) * e1[i] + longint'(b) * e2[i]) >>> 8) - o[i];
			if (mode < 3) d[i] = d[i] >>> k;
			else if (mode == 3) d[i] = -d[i];
		end
		it.orig = pack3(o[0], o[1], o[2]);
		it.dir = pack3(d[0], d[1], d[2]);
		it.v0 = pack3(v0[0], v0[1], v0[2]);
		it.v1 = pack3(v0[0] + e1[0], v0[1] + e1[1], v0[2] + e1[2]);
		it.v2 = pack3(v0[0] + e2[0], v0[1] + e2[1], v0[2] + e2[2]);
		if ($urandom_range(1)) {it.v1, it.v2} = {it.v2, it.v1};
		return it;
	endfunction

	function automatic logic [FW-1:0] rand_field();
		return FW'({$urandom, $urandom});
	endfunction

	task automatic queue_random(int count);
		ray_tri_t it;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 20)
				it = '{rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
			else
				it = aimed_ray();
			pending_rays.push_back(it);
		end
	endtask

	task automatic drain();
		while (pending_rays.size() > 0 || expected_hits.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic queue_directed();
		logic [FW-1:0] max_pos, max_neg;
		max_pos = pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		max_neg = pack3(-(1 << 20), -(1 << 20), -(1 << 20));
		// degenerate and extreme fields
		pending_rays.push_back('{'0, '0, '0, '0, '0});
		pending_rays.push_back('{'1, '1, '1, '1, '1});
		pending_rays.push_back('{max_pos, max_neg, max_neg, max_pos, pack3(1 << 19, 0, 0)});
		pending_rays.push_back('{max_neg, max_pos, pack3(0, 0, 1 << 19),
			pack3(1 << 19, 0, 1 << 19), pack3(0, 1 << 19, 1 << 19)});
		// plain hit in front, then with winding reversed
		pending_rays.push_back('{pack3(100, 100, -1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		pending_rays.push_back('{pack3(100, 100, -1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(0, 1024, 1024), pack3(1024, 0, 1024)});
		// corners and edge
		pending_rays.push_back('{pack3(0, 0, -1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		pending_rays.push_back('{pack3(1024, 0, -1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		pending_rays.push_back('{pack3(512, 512, -1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		// just outside the edge, behind the origin, origin on the plane
		pending_rays.push_back('{pack3(513, 512, -1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		pending_rays.push_back('{pack3(100, 100, 2048), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		pending_rays.push_back('{pack3(100, 100, 1024), pack3(0, 0, 1024),
			pack3(0, 0, 1024), pack3(1024, 0, 1024), pack3(0, 1024, 1024)});
		// tiny triangle, determinant near the threshold
		pending_rays.push_back('{pack3(0, 0, -1024), pack3(0, 0, 1),
			pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0)});
		pending_rays.push_back('{pack3(0, 0, -1024), pack3(0, 0, 1),
			pack3(0, 0, 0), pack3(11, 0, 0), pack3(0, 10, 0)});
		// saturated distance
		pending_rays.push_back('{pack3(0, 0, -(1 << 20)), pack3(0, 0, 1),
			pack3(-4096, -4096, (1 << 20) - 1), pack3(4096, 0, (1 << 20) - 1),
			pack3(0, 4096, (1 << 20) - 1)});
		// ray parallel to the plane
		pending_rays.push_back('{pack3(0, 0, -1024), pack3(1024, 0, 0),
			pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 1024, 0)});
		for (int n = 0; n < 6; n++) pending_rays.push_back(aimed_ray());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 0;
		queue_directed();
		queue_random(400);
		drain();
		write_reg(rti_pkg::REG_DET_EPS, 32'd0);
		write_reg(rti_pkg::REG_T_EPS, 32'd0);
		idle_pct = 76;
		queue_directed();
		queue_random(380);
		drain();
		write_reg(rti_pkg::REG_DET_EPS, 32'hFFFFF);
		write_reg(rti_pkg::REG_T_EPS, 32'hFFFF);
		idle_pct = 27;
		queue_directed();
		queue_random(380);
		drain();
		write_reg(rti_pkg::REG_DET_EPS, 32'd1);
		write_reg(rti_pkg::REG_T_EPS, 32'h10001);
		idle_pct = 0;
		queue_random(380);
		drain();
		write_reg(rti_pkg::REG_DET_EPS, $urandom_range(0, 32'hFFFFF));
		write_reg(rti_pkg::REG_T_EPS, $urandom_range(0, 1 << 17));
		idle_pct = 50;
		queue_random(380);
		drain();
		$display("checked %0d results, %0d hits, over five register settings", results_seen,
			hits_seen);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
